>>> rtl/core/shs_pkg.sv
// Shared constants, types and the default turn table of the spool height converter.
package shs_pkg;

  localparam int TABLE_DEPTH = 32;

  localparam int HEIGHT_W   = 16;
  localparam int STEPS_W    = 24;
  localparam int CIRC_W     = 16;
  localparam int INDEX_W    = 5;
  localparam int REST_W     = 20;                // height * 10 in tenths of mm
  localparam int DVD_W      = 44;                // steps_left * rest
  localparam int DVS_W      = 20;                // mm_left * 10
  localparam int CFG_DATA_W = 24;
  localparam int CFG_IDX_W  = 1;
  localparam int S_TDATA_W  = 40;
  localparam int M_TDATA_W  = 24;
  localparam int DEF_IDX_W  = 6;

  localparam logic [HEIGHT_W-1:0] MAX_HEIGHT_RST = 16'd1500;
  localparam logic [STEPS_W-1:0]  MAX_STEPS_RST  = 24'd29100;
  localparam logic [10:0]         STEPS_PER_TURN = 11'd2000;

  // x / 10 == (x * RECIP10) >> RECIP_SHIFT, exact for x below 2**22
  localparam logic [19:0] RECIP10     = 20'd838861;
  localparam int          RECIP_SHIFT = 23;

  typedef enum logic {
    CMD_CONVERT = 1'b0,
    CMD_WRITE   = 1'b1
  } shs_op_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_MAX_HEIGHT = 1'b0,
    REG_MAX_STEPS  = 1'b1
  } shs_reg_t;

  typedef struct packed {
    logic write_entry;
    logic start;
    logic advance;
    logic part_div;
    logic lin_prod;
    logic lin_scale;
    logic lin_div;
    logic load_quot;
    logic load_max;
  } shs_cmd_t;

  typedef struct packed {
    logic over;
    logic at_end;
    logic circ_zero;
    logic rest_lt_circ;
    logic turn_sat;
    logic no_height_left;
    logic div_busy;
  } shs_status_t;

  function automatic logic [CIRC_W-1:0] default_circ(input logic [DEF_IDX_W-1:0] idx);
    logic [CIRC_W-1:0] val;
    case (idx)
      6'd0:    val = 16'd800;
      6'd1:    val = 16'd780;
      6'd2:    val = 16'd830;
      6'd3:    val = 16'd910;
      6'd4:    val = 16'd910;
      6'd5:    val = 16'd950;
      6'd6:    val = 16'd1060;
      6'd7:    val = 16'd1020;
      6'd8:    val = 16'd1050;
      6'd9:    val = 16'd1160;
      6'd10:   val = 16'd1150;
      6'd11:   val = 16'd1200;
      6'd12:   val = 16'd1260;
      6'd13:   val = 16'd1270;
      default: val = 16'd0;
    endcase
    return val;
  endfunction

endpackage

>>> rtl/core/shs_ram.sv
// Generic single-port-write, registered-read RAM.
module shs_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 32
) (
  input  logic                                   clk,
  input  logic                                   we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                       wdata,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                       rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

>>> rtl/core/shs_divider.sv
// Radix-2 restoring divider, one quotient bit per cycle.
module shs_divider (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     start,
  input  logic [shs_pkg::DVD_W-1:0] dividend,
  input  logic [shs_pkg::DVS_W-1:0] divisor,
  output logic                     busy,
  output logic [shs_pkg::DVD_W-1:0] quotient
);

  localparam int DW = shs_pkg::DVD_W;
  localparam int SW = shs_pkg::DVS_W;
  localparam int CNT_W = $clog2(DW + 1);

  logic [DW-1:0]    quo;
  logic [SW-1:0]    rem;
  logic [SW-1:0]    dvs;
  logic [CNT_W-1:0] count;
  logic [SW:0]      rem_sh;
  logic [SW:0]      diff;
  logic             ge;

  assign rem_sh   = {rem, quo[DW-1]};
  assign diff     = rem_sh - {1'b0, dvs};
  assign ge       = rem_sh >= {1'b0, dvs};
  assign quotient = quo;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy  <= 1'b0;
      count <= '0;
    end else if (start) begin
      busy  <= 1'b1;
      count <= CNT_W'(DW);
    end else if (busy) begin
      count <= count - 1'b1;
      busy  <= (count != CNT_W'(1));
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      quo <= dividend;
      rem <= '0;
      dvs <= divisor;
    end else if (busy) begin
      quo <= {quo[DW-2:0], ge};
      rem <= ge ? diff[SW-1:0] : rem_sh[SW-1:0];
    end
  end

endmodule

>>> rtl/core/shs_datapath.sv
// Datapath: settings, turn table, walk registers, multipliers and divider.
module shs_datapath #(
  parameter int TABLE_DEPTH = shs_pkg::TABLE_DEPTH
) (
  input  logic                          clk,
  input  logic                          rst,
  input  shs_pkg::shs_cmd_t             cmd,
  output shs_pkg::shs_status_t          status,
  input  logic [shs_pkg::HEIGHT_W-1:0]  in_height,
  input  logic [shs_pkg::INDEX_W-1:0]   in_index,
  input  logic [shs_pkg::CIRC_W-1:0]    in_value,
  input  logic                          cfg_valid,
  input  logic [shs_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [shs_pkg::CFG_DATA_W-1:0] cfg_data,
  output logic [shs_pkg::STEPS_W-1:0]   steps_out
);

  localparam int AW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
  localparam int NW = $clog2(TABLE_DEPTH + 1);
  localparam int HW = shs_pkg::HEIGHT_W;
  localparam int TW = shs_pkg::STEPS_W;
  localparam int CW = shs_pkg::CIRC_W;
  localparam int RW = shs_pkg::REST_W;
  localparam int PW = 2 * RW;

  logic [HW-1:0]    max_height;
  logic [TW-1:0]    max_steps;
  logic [TABLE_DEPTH-1:0] entry_valid;

  logic [RW-1:0]    rest;
  logic [RW-1:0]    covered;
  logic [TW-1:0]    steps;
  logic [NW-1:0]    n;
  logic             over;
  logic [PW-1:0]    done_prod;
  logic [shs_pkg::DVS_W-1:0] divisor10;
  logic [shs_pkg::DVD_W-1:0] lin_prod;

  logic             index_ok;
  logic             we;
  logic [AW-1:0]    waddr;
  logic [AW-1:0]    addr;
  logic [CW-1:0]    rd_data;
  logic [CW-1:0]    entry;
  logic [TW:0]      turn_sum;
  logic [HW:0]      done_mm;
  logic [HW-1:0]    mm_left;
  logic [shs_pkg::DVS_W-1:0] mm_left10;
  logic [TW-1:0]    steps_left;
  logic [30:0]      part_num;
  logic             div_start;
  logic [shs_pkg::DVD_W-1:0] div_dividend;
  logic [shs_pkg::DVS_W-1:0] div_divisor;
  logic             div_busy;
  logic [shs_pkg::DVD_W-1:0] quot;
  logic [TW:0]      fin_sum;
  logic             fin_sat;

  assign index_ok = (7'(in_index) < 7'(TABLE_DEPTH));
  assign we       = cmd.write_entry & index_ok;
  assign waddr    = AW'(in_index);
  assign addr     = n[AW-1:0];

  shs_ram #(
    .WIDTH (CW),
    .DEPTH (TABLE_DEPTH)
  ) u_table (
    .clk   (clk),
    .we    (we),
    .waddr (waddr),
    .wdata (in_value),
    .raddr (addr),
    .rdata (rd_data)
  );

  // Entries never written read as the default table
  assign entry = entry_valid[addr] ? rd_data
                                   : shs_pkg::default_circ(shs_pkg::DEF_IDX_W'(addr));

  assign turn_sum   = {1'b0, steps} + (TW + 1)'(shs_pkg::STEPS_PER_TURN);
  assign done_mm    = done_prod[shs_pkg::RECIP_SHIFT +: (HW + 1)];
  assign mm_left    = max_height - done_mm[HW-1:0];
  assign mm_left10  = {1'b0, mm_left, 3'b000} + {3'b000, mm_left, 1'b0};
  assign steps_left = max_steps - steps;
  assign part_num   = 31'(rest) * 31'(shs_pkg::STEPS_PER_TURN);

  assign div_start    = cmd.part_div | cmd.lin_div;
  assign div_dividend = cmd.part_div ? shs_pkg::DVD_W'(part_num) : lin_prod;
  assign div_divisor  = cmd.part_div ? shs_pkg::DVS_W'(entry) : divisor10;

  shs_divider u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (div_dividend),
    .divisor  (div_divisor),
    .busy     (div_busy),
    .quotient (quot)
  );

  assign fin_sum = {1'b0, steps} + {1'b0, quot[TW-1:0]};
  assign fin_sat = (|quot[shs_pkg::DVD_W-1:TW]) | (fin_sum > {1'b0, max_steps});

  always_comb begin
    status.over           = over;
    status.at_end         = (n == NW'(TABLE_DEPTH));
    status.circ_zero      = (entry == '0);
    status.rest_lt_circ   = (rest < RW'(entry));
    status.turn_sat       = (turn_sum > {1'b0, max_steps});
    status.no_height_left = ({1'b0, max_height} <= done_mm);
    status.div_busy       = div_busy;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      max_height  <= shs_pkg::MAX_HEIGHT_RST;
      max_steps   <= shs_pkg::MAX_STEPS_RST;
      entry_valid <= '0;
    end else begin
      if (cfg_valid) begin
        unique case (shs_pkg::shs_reg_t'(cfg_index))
          shs_pkg::REG_MAX_HEIGHT: max_height <= cfg_data[HW-1:0];
          shs_pkg::REG_MAX_STEPS:  max_steps  <= cfg_data[TW-1:0];
          default: ;
        endcase
      end
      if (we) begin
        entry_valid[waddr] <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.start) begin
      rest    <= {1'b0, in_height, 3'b000} + {3'b000, in_height, 1'b0};
      covered <= '0;
      steps   <= '0;
      n       <= '0;
      over    <= (in_height > max_height);
    end
    if (cmd.advance) begin
      rest    <= rest - RW'(entry);
      covered <= covered + RW'(entry);
      steps   <= turn_sum[TW-1:0];
      n       <= n + 1'b1;
    end
    if (cmd.lin_prod) begin
      done_prod <= PW'(covered) * PW'(shs_pkg::RECIP10);
    end
    if (cmd.lin_scale) begin
      divisor10 <= mm_left10;
      lin_prod  <= shs_pkg::DVD_W'(steps_left) * shs_pkg::DVD_W'(rest);
    end
    if (cmd.load_max) begin
      steps_out <= max_steps;
    end else if (cmd.load_quot) begin
      steps_out <= fin_sat ? max_steps : fin_sum[TW-1:0];
    end
  end

endmodule

>>> rtl/core/shs_ctrl.sv
// Controller: sequences the table walk, the division and the result handoff.
module shs_ctrl (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  input  shs_pkg::shs_op_t     in_op,
  output logic                 in_ready,
  output logic                 out_valid,
  input  logic                 out_ready,
  input  shs_pkg::shs_status_t status,
  output shs_pkg::shs_cmd_t    cmd
);

  typedef enum logic [3:0] {
    S_IDLE,
    S_CHECK,
    S_READ,
    S_EVAL,
    S_LIN_PROD,
    S_LIN_SCALE,
    S_LIN_DIV,
    S_DIV,
    S_FIN,
    S_SAT
  } state_t;

  state_t state;
  state_t state_next;
  logic   slot_free;

  assign slot_free = !out_valid || out_ready;

  always_comb begin
    state_next = state;
    cmd        = '0;
    in_ready   = 1'b0;
    unique case (state)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          if (in_op == shs_pkg::CMD_WRITE) begin
            cmd.write_entry = 1'b1;
          end else begin
            cmd.start  = 1'b1;
            state_next = S_CHECK;
          end
        end
      end
      S_CHECK: state_next = status.over ? S_SAT : S_READ;
      S_READ:  state_next = status.at_end ? S_SAT : S_EVAL;
      S_EVAL: begin
        if (status.circ_zero) begin
          state_next = S_LIN_PROD;
        end else if (status.rest_lt_circ) begin
          cmd.part_div = 1'b1;
          state_next   = S_DIV;
        end else if (status.turn_sat) begin
          state_next = S_SAT;
        end else begin
          cmd.advance = 1'b1;
          state_next  = S_READ;
        end
      end
      S_LIN_PROD: begin
        cmd.lin_prod = 1'b1;
        state_next   = S_LIN_SCALE;
      end
      S_LIN_SCALE: begin
        if (status.no_height_left) begin
          state_next = S_SAT;
        end else begin
          cmd.lin_scale = 1'b1;
          state_next    = S_LIN_DIV;
        end
      end
      S_LIN_DIV: begin
        cmd.lin_div = 1'b1;
        state_next  = S_DIV;
      end
      S_DIV: begin
        if (!status.div_busy) begin
          state_next = S_FIN;
        end
      end
      S_FIN: begin
        if (slot_free) begin
          cmd.load_quot = 1'b1;
          state_next    = S_IDLE;
        end
      end
      S_SAT: begin
        if (slot_free) begin
          cmd.load_max = 1'b1;
          state_next   = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (cmd.load_quot || cmd.load_max) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

endmodule

>>> rtl/core/spool_height_to_steps_core.sv
// Top level of the spool height to stepper steps converter.
//
//  channel  | direction | handshake                    | payload
//  ---------+-----------+------------------------------+----------------------------------
//  s_axis   | in        | s_axis_tvalid/s_axis_tready  | tuser: cmd; tdata: height, entry
//  m_axis   | out       | m_axis_tvalid/m_axis_tready  | tdata: steps
//  cfg      | in        | cfg_valid/cfg_ready          | cfg_index, cfg_data
//
// A table write leaves the core idle. A convert walks the whole turns, each through a
// registered table read, then runs a serial 44-bit divide for the partial turn or for the
// linear spread from the first zero entry on; reaching the table end gives max_steps. Heights
// above travel skip the walk; a turn that overruns max_steps ends the walk without a divide.
// Reset is synchronous; it restores the settings and marks every table entry as default.
// A convert is taken while a result waits on m_axis; it holds before the output register.
module spool_height_to_steps_core #(
  parameter int TABLE_DEPTH = shs_pkg::TABLE_DEPTH
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           s_axis_tvalid,
  output logic                           s_axis_tready,
  // [15:0] height_mm, [20:16] entry_index, [36:21] entry_value, [39:37] zero
  input  logic [shs_pkg::S_TDATA_W-1:0]  s_axis_tdata,
  // [0] cmd
  input  logic                           s_axis_tuser,
  output logic                           m_axis_tvalid,
  input  logic                           m_axis_tready,
  // [23:0] steps
  output logic [shs_pkg::M_TDATA_W-1:0]  m_axis_tdata,
  input  logic                           cfg_valid,
  output logic                           cfg_ready,
  input  logic [shs_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [shs_pkg::CFG_DATA_W-1:0] cfg_data
);

  shs_pkg::shs_cmd_t    cmd;
  shs_pkg::shs_status_t status;
  logic                 cfg_write;

  // Settings must change only while idle; the block does not enforce it and takes every write at once
  assign cfg_ready = 1'b1;
  assign cfg_write = cfg_valid & cfg_ready;

  shs_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (s_axis_tvalid),
    .in_op     (shs_pkg::shs_op_t'(s_axis_tuser)),
    .in_ready  (s_axis_tready),
    .out_valid (m_axis_tvalid),
    .out_ready (m_axis_tready),
    .status    (status),
    .cmd       (cmd)
  );

  // Unpack the input transaction: height, then table index, then table value
  shs_datapath #(
    .TABLE_DEPTH (TABLE_DEPTH)
  ) u_dp (
    .clk       (clk),
    .rst       (rst),
    .cmd       (cmd),
    .status    (status),
    .in_height (s_axis_tdata[15:0]),
    .in_index  (s_axis_tdata[20:16]),
    .in_value  (s_axis_tdata[36:21]),
    .cfg_valid (cfg_write),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .steps_out (m_axis_tdata)
  );

endmodule

>>> rtl/core/shs_checker.sv
// Port-level checks for the spool height converter, bound to the top level.
module shs_checker (
  input logic                          clk,
  input logic                          rst,
  input logic                          s_axis_tvalid,
  input logic                          s_axis_tready,
  input logic                          s_axis_tuser,
  input logic                          m_axis_tvalid,
  input logic                          m_axis_tready,
  input logic [shs_pkg::M_TDATA_W-1:0] m_axis_tdata
);

  // Hold a stalled result
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("result dropped or changed while stalled");

  // A table write never produces a result
  a_write_silent: assert property (@(posedge clk) disable iff (rst)
    s_axis_tvalid && s_axis_tready && s_axis_tuser && !m_axis_tvalid |=> !m_axis_tvalid)
    else $error("result appeared after a table write");

  // A convert keeps the input closed while it works
  a_convert_busy: assert property (@(posedge clk) disable iff (rst)
    s_axis_tvalid && s_axis_tready && !s_axis_tuser |=> !s_axis_tready)
    else $error("input reopened right after a convert");

  // Reset leaves no result pending
  a_reset_empty: assert property (@(posedge clk)
    $past(rst) |-> !m_axis_tvalid)
    else $error("result valid after reset");

endmodule

bind spool_height_to_steps_core shs_checker u_shs_checker (
  .clk           (clk),
  .rst           (rst),
  .s_axis_tvalid (s_axis_tvalid),
  .s_axis_tready (s_axis_tready),
  .s_axis_tuser  (s_axis_tuser),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata)
);
